>>> src/sbc_pkg.sv
// Package for the self-balance cascade controller.
// Field widths, fixed-point constants, register indexes and reset values.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package sbc_pkg;

    // Fraction bits of gains, filtered speed, position and speed term
    localparam int FRAC_BITS = 8;

    // Transaction field widths
    localparam int ANGLE_W = 17;
    localparam int RATE_W  = 16;
    localparam int PULSE_W = 16;
    localparam int CMD_W   = 12;
    localparam int DRIVE_W = 13;

    // Configuration register widths
    localparam int GAIN_W     = 16;
    localparam int PLIM_W     = 15;
    localparam int DLIM_W     = 12;
    localparam int TLIM_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN_D    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_P   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_I   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT     = 3'd6;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] RST_TILT_GAIN_P    = 16'd24673;
    localparam logic [GAIN_W-1:0] RST_TILT_GAIN_D    = 16'd1577;
    localparam logic [GAIN_W-1:0] RST_SPEED_GAIN_P   = 16'd7150;
    localparam logic [GAIN_W-1:0] RST_SPEED_GAIN_I   = 16'd80;
    localparam logic [PLIM_W-1:0] RST_POSITION_LIMIT = 15'd5000;
    localparam logic [DLIM_W-1:0] RST_DRIVE_LIMIT    = 12'd900;
    localparam logic [TLIM_W-1:0] RST_TILT_LIMIT     = 8'd55;

    // Filtered speed stays within +-(2^(PULSE_W+FRAC_BITS-1)+1)
    localparam int SF_W  = PULSE_W + FRAC_BITS + 1;
    // Filter numerator 8*f + sum*2^FRAC_BITS, and its rounded magnitude
    localparam int NUM_W = PULSE_W + FRAC_BITS + 4;
    localparam int MAG_W = NUM_W - 1;

    // Divide by ten: multiply by ceil(2^35/10), keep the bits from bit 35 up
    localparam int                 RECIP_W   = 32;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int                 DIV_SHIFT = 35;
    localparam int                 DIV_HALF  = 5;

    // Shared multiplier operands and product
    localparam int MUL_A_W = NUM_W;
    localparam int MUL_B_W = RECIP_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Speed loop widths
    localparam int POS_W    = PLIM_W + FRAC_BITS + 1;
    localparam int RG_W     = GAIN_W + SF_W - FRAC_BITS + 1;
    localparam int PS_W     = RG_W + 2;
    localparam int ST_W     = 32;
    localparam int ST_SUM_W = RG_W + 1;

    // Drive sum: gains times angle and rate, speed term and turn, all scaled
    localparam int SPEED_SHIFT = 8;
    localparam int RATE_SHIFT  = 4;
    localparam int TILT_SHIFT  = 8;
    localparam int ACC_W       = ST_W + SPEED_SHIFT + 2;
    localparam int DRV_SHIFT   = FRAC_BITS + 8;

endpackage

>>> src/sbc_in_if.sv
// Input channel of the self-balance cascade controller: valid, ready, tick fields.
// Depends on sbc_pkg for the field widths.
`timescale 1ns / 1ps

interface sbc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sbc_pkg::ANGLE_W-1:0]   tilt_angle;
    logic signed [sbc_pkg::RATE_W-1:0]    tilt_rate;
    logic signed [sbc_pkg::PULSE_W-1:0]   left_pulses;
    logic signed [sbc_pkg::PULSE_W-1:0]   right_pulses;
    logic                                 speed_update;
    logic signed [sbc_pkg::CMD_W-1:0]     speed_command;
    logic signed [sbc_pkg::CMD_W-1:0]     turn_command;

    modport source (
        output valid, tilt_angle, tilt_rate, left_pulses, right_pulses,
               speed_update, speed_command, turn_command,
        input  ready
    );

    modport sink (
        input  valid, tilt_angle, tilt_rate, left_pulses, right_pulses,
               speed_update, speed_command, turn_command,
        output ready
    );
endinterface

>>> src/sbc_out_if.sv
// Output channel of the self-balance cascade controller: valid, ready, drives.
// Depends on sbc_pkg for the field widths.
`timescale 1ns / 1ps

interface sbc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sbc_pkg::DRIVE_W-1:0]   left_drive;
    logic signed [sbc_pkg::DRIVE_W-1:0]   right_drive;
    logic                                 tilted_over;

    modport source (
        output valid, left_drive, right_drive, tilted_over,
        input  ready
    );

    modport sink (
        input  valid, left_drive, right_drive, tilted_over,
        output ready
    );
endinterface

>>> src/self_balance_cascade_controller.sv
// Self-balance cascade controller top level: tilt PD loop plus wheel speed PI loop.
// Depends on sbc_pkg, sbc_in_if and sbc_out_if.
`timescale 1ns / 1ps

// One control tick per input transaction, one drive transaction out. All products
// run through a single signed multiplier, stepped by a small one-hot sequencer
// with the product registered between steps. A tick without a speed update steps
// from acceptance to the next ready through two multiplier steps, the drive sum
// and the output write; a tick with a speed update adds, before them, the
// filter numerator, the divide by ten, the filter update, the two speed-loop
// products and the speed term. The output register holds one finished
// transaction, so the next tick is accepted while it waits; the sequencer stalls
// only at the output write when that register is still full. Configuration
// registers take effect for the next tick and must be written while idle.
module self_balance_cascade_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    sbc_in_if.sink                              i_in,
    sbc_out_if.source                           o_out
);

    localparam int F      = sbc_pkg::FRAC_BITS;
    localparam int A_W    = sbc_pkg::MUL_A_W;
    localparam int B_W    = sbc_pkg::MUL_B_W;
    localparam int P_W    = sbc_pkg::PROD_W;
    localparam int SF_W   = sbc_pkg::SF_W;
    localparam int NUM_W  = sbc_pkg::NUM_W;
    localparam int MAG_W  = sbc_pkg::MAG_W;
    localparam int POS_W  = sbc_pkg::POS_W;
    localparam int RG_W   = sbc_pkg::RG_W;
    localparam int PS_W   = sbc_pkg::PS_W;
    localparam int ST_W   = sbc_pkg::ST_W;
    localparam int SS_W   = sbc_pkg::ST_SUM_W;
    localparam int ACC_W  = sbc_pkg::ACC_W;
    localparam int D_SH   = sbc_pkg::DRV_SHIFT;
    localparam int PW     = sbc_pkg::PULSE_W;
    localparam int TA_W   = sbc_pkg::ANGLE_W + 1;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_NUM  = 11'b000_0000_0010,
        ST_DIV  = 11'b000_0000_0100,
        ST_SF   = 11'b000_0000_1000,
        ST_GI   = 11'b000_0001_0000,
        ST_GP   = 11'b000_0010_0000,
        ST_TERM = 11'b000_0100_0000,
        ST_TP   = 11'b000_1000_0000,
        ST_TD   = 11'b001_0000_0000,
        ST_SUM  = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } t_state;

    // Configuration registers
    logic [sbc_pkg::GAIN_W-1:0] r_gain_tp, r_gain_td, r_gain_sp, r_gain_si;
    logic [sbc_pkg::PLIM_W-1:0] r_plim;
    logic [sbc_pkg::DLIM_W-1:0] r_dlim;
    logic [sbc_pkg::TLIM_W-1:0] r_tlim;

    // Control and loop state
    t_state                      r_state, n_state;
    logic [PW-1:0]               r_lsum, r_rsum;
    logic signed [SF_W-1:0]      r_sf;
    logic signed [POS_W-1:0]     r_pos;
    logic signed [ST_W-1:0]      r_st;
    logic                        r_out_valid;

    // Latched tick fields and working registers
    logic signed [sbc_pkg::ANGLE_W-1:0] r_angle;
    logic signed [sbc_pkg::RATE_W-1:0]  r_rate;
    logic signed [sbc_pkg::CMD_W-1:0]   r_cmd, r_turn;
    logic                               r_over;
    logic [MAG_W-1:0]                   r_mag;
    logic                               r_neg;
    logic signed [P_W-1:0]              r_prod;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [sbc_pkg::DRIVE_W-1:0] r_left, r_right;
    logic                               r_tilted;

    logic in_fire, out_free;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.left_drive  = r_left;
    assign o_out.right_drive = r_right;
    assign o_out.tilted_over = r_tilted;

    // Tilt stop test against the whole-degree limit
    logic signed [TA_W-1:0] tilt_lim, angle_x;
    logic                   over_now;
    assign tilt_lim = $signed(TA_W'({r_tlim, {sbc_pkg::TILT_SHIFT{1'b0}}}));
    assign angle_x  = TA_W'(i_in.tilt_angle);
    assign over_now = !((angle_x < tilt_lim) && (angle_x > -tilt_lim));

    // Pulse accumulation, right count negated
    logic [PW-1:0] lsum_acc, rsum_acc;
    assign lsum_acc = r_lsum + i_in.left_pulses;
    assign rsum_acc = r_rsum - i_in.right_pulses;

    // Filter numerator 8*old + (L+R)*2^F and its magnitude plus half of ten
    logic signed [PW:0]      pulse_sum;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_abs;
    assign pulse_sum = $signed({r_lsum[PW-1], r_lsum}) + $signed({r_rsum[PW-1], r_rsum});
    assign num       = (NUM_W'(r_sf) <<< 3) + (NUM_W'(pulse_sum) <<< F);
    assign num_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // Shared multiplier operand select
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_DIV: begin
                mul_a = $signed(A_W'(r_mag));
                mul_b = $signed(B_W'(sbc_pkg::RECIP_TEN));
            end
            ST_GI: begin
                mul_a = A_W'(r_sf);
                mul_b = $signed(B_W'(r_gain_si));
            end
            ST_GP: begin
                mul_a = A_W'(r_sf);
                mul_b = $signed(B_W'(r_gain_sp));
            end
            ST_TP: begin
                mul_a = A_W'(r_angle);
                mul_b = $signed(B_W'(r_gain_tp));
            end
            ST_TD: begin
                mul_a = A_W'(r_rate);
                mul_b = $signed(B_W'(r_gain_td));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Quotient of the divide by ten, sign restored
    logic [SF_W-1:0]        quot;
    logic signed [SF_W-1:0] sf_new;
    assign quot   = r_prod[sbc_pkg::DIV_SHIFT +: SF_W];
    assign sf_new = r_neg ? -$signed(quot) : $signed(quot);

    // Product rounded by 2^F, halves away from zero
    logic signed [P_W-1:0]  prod_bias, prod_rnd;
    logic signed [RG_W-1:0] gain_rnd;
    assign prod_bias = r_prod + $signed(P_W'(2 ** (F - 1)))
                     - $signed(P_W'(r_prod[P_W-1]));
    assign prod_rnd  = prod_bias >>> F;
    assign gain_rnd  = prod_rnd[RG_W-1:0];

    // Position integrator with saturation
    logic signed [PS_W-1:0] pos_sum, plim_s, pos_sat;
    assign plim_s  = $signed(PS_W'({r_plim, {F{1'b0}}}));
    assign pos_sum = PS_W'(r_pos) + (PS_W'(r_cmd) <<< F) + PS_W'(gain_rnd);
    assign pos_sat = (pos_sum > plim_s) ? plim_s :
                     (pos_sum < -plim_s) ? -plim_s : pos_sum;

    // Speed term saturated to 32 bits
    logic signed [SS_W-1:0] st_sum, st_sat;
    localparam logic signed [SS_W-1:0] ST_MAX =
        $signed({{(SS_W - ST_W + 1){1'b0}}, {(ST_W - 1){1'b1}}});
    localparam logic signed [SS_W-1:0] ST_MIN = ~ST_MAX;
    assign st_sum = SS_W'(gain_rnd) + SS_W'(r_pos);
    assign st_sat = (st_sum > ST_MAX) ? ST_MAX : (st_sum < ST_MIN) ? ST_MIN : st_sum;

    // Drive sums with turn, rounded by 2^(F+8) and saturated
    logic signed [ACC_W-1:0] turn_term, sum_l, sum_r, rnd_l, rnd_r, dlim_s;
    logic signed [ACC_W-1:0] drv_l, drv_r;
    assign turn_term = ACC_W'(r_turn) <<< D_SH;
    assign sum_l     = r_acc + turn_term;
    assign sum_r     = r_acc - turn_term;
    assign rnd_l     = (sum_l + $signed(ACC_W'(2 ** (D_SH - 1)))
                      - $signed(ACC_W'(sum_l[ACC_W-1]))) >>> D_SH;
    assign rnd_r     = (sum_r + $signed(ACC_W'(2 ** (D_SH - 1)))
                      - $signed(ACC_W'(sum_r[ACC_W-1]))) >>> D_SH;
    assign dlim_s    = $signed(ACC_W'(r_dlim));
    assign drv_l     = (rnd_l > dlim_s) ? dlim_s : (rnd_l < -dlim_s) ? -dlim_s : rnd_l;
    assign drv_r     = (rnd_r > dlim_s) ? dlim_s : (rnd_r < -dlim_s) ? -dlim_s : rnd_r;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) begin
                n_state = i_in.speed_update ? ST_NUM : ST_TP;
            end
            ST_NUM:  n_state = ST_DIV;
            ST_DIV:  n_state = ST_SF;
            ST_SF:   n_state = ST_GI;
            ST_GI:   n_state = ST_GP;
            ST_GP:   n_state = ST_TERM;
            ST_TERM: n_state = ST_TP;
            ST_TP:   n_state = ST_TD;
            ST_TD:   n_state = ST_SUM;
            ST_SUM:  n_state = ST_OUT;
            ST_OUT:  if (out_free) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_tp <= sbc_pkg::RST_TILT_GAIN_P;
            r_gain_td <= sbc_pkg::RST_TILT_GAIN_D;
            r_gain_sp <= sbc_pkg::RST_SPEED_GAIN_P;
            r_gain_si <= sbc_pkg::RST_SPEED_GAIN_I;
            r_plim    <= sbc_pkg::RST_POSITION_LIMIT;
            r_dlim    <= sbc_pkg::RST_DRIVE_LIMIT;
            r_tlim    <= sbc_pkg::RST_TILT_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sbc_pkg::REG_TILT_GAIN_P:    r_gain_tp <= i_cfg_data;
                sbc_pkg::REG_TILT_GAIN_D:    r_gain_td <= i_cfg_data;
                sbc_pkg::REG_SPEED_GAIN_P:   r_gain_sp <= i_cfg_data;
                sbc_pkg::REG_SPEED_GAIN_I:   r_gain_si <= i_cfg_data;
                sbc_pkg::REG_POSITION_LIMIT: r_plim    <= i_cfg_data[sbc_pkg::PLIM_W-1:0];
                sbc_pkg::REG_DRIVE_LIMIT:    r_dlim    <= i_cfg_data[sbc_pkg::DLIM_W-1:0];
                sbc_pkg::REG_TILT_LIMIT:     r_tlim    <= i_cfg_data[sbc_pkg::TLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, loop state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lsum      <= '0;
            r_rsum      <= '0;
            r_sf        <= '0;
            r_pos       <= '0;
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Raise the output transaction on a finished tick, drop it once taken
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: if (in_fire) begin
                    r_lsum <= lsum_acc;
                    r_rsum <= rsum_acc;
                end
                ST_SF: begin
                    r_sf   <= sf_new;
                    r_lsum <= '0;
                    r_rsum <= '0;
                end
                ST_GP:   r_pos <= pos_sat[POS_W-1:0];
                ST_TERM: r_st  <= st_sat[ST_W-1:0];
                ST_OUT: if (out_free) begin
                    if (r_over) begin
                        r_pos <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            ST_IDLE: if (in_fire) begin
                r_angle <= i_in.tilt_angle;
                r_rate  <= i_in.tilt_rate;
                r_cmd   <= i_in.speed_command;
                r_turn  <= i_in.turn_command;
                r_over  <= over_now;
            end
            ST_NUM: begin
                r_neg <= num[NUM_W-1];
                r_mag <= MAG_W'(num_abs) + MAG_W'(sbc_pkg::DIV_HALF);
            end
            ST_TD:  r_acc <= r_prod[ACC_W-1:0] - ((ACC_W'(r_st)) <<< sbc_pkg::SPEED_SHIFT);
            ST_SUM: r_acc <= r_acc - (r_prod[ACC_W-1:0] <<< sbc_pkg::RATE_SHIFT);
            ST_OUT: if (out_free) begin
                if (r_over) begin
                    r_left  <= '0;
                    r_right <= '0;
                end else begin
                    r_left  <= drv_l[sbc_pkg::DRIVE_W-1:0];
                    r_right <= drv_r[sbc_pkg::DRIVE_W-1:0];
                end
                r_tilted <= r_over;
            end
            default: ;
        endcase
    end

endmodule

>>> bench/self_balance_cascade_controller_tb.sv
// Testbench for the self-balance cascade controller: directed table plus random ticks,
// checked against a cycle-free predictor of the tilt PD and wheel speed PI loops.
// Depends on sbc_pkg, sbc_in_if, sbc_out_if and self_balance_cascade_controller.
`timescale 1ns / 1ps

module self_balance_cascade_controller_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 20;

    localparam int FRAC_BITS  = sbc_pkg::FRAC_BITS;
    localparam int ANGLE_W    = sbc_pkg::ANGLE_W;
    localparam int RATE_W     = sbc_pkg::RATE_W;
    localparam int PULSE_W    = sbc_pkg::PULSE_W;
    localparam int CMD_W      = sbc_pkg::CMD_W;
    localparam int DRIVE_W    = sbc_pkg::DRIVE_W;
    localparam int GAIN_W     = sbc_pkg::GAIN_W;
    localparam int PLIM_W     = sbc_pkg::PLIM_W;
    localparam int DLIM_W     = sbc_pkg::DLIM_W;
    localparam int TLIM_W     = sbc_pkg::TLIM_W;
    localparam int CFG_IDX_W  = sbc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sbc_pkg::CFG_DATA_W;

    // One control tick and one drive transaction, raw bits at the port widths
    typedef struct packed {
        logic [ANGLE_W-1:0] tilt_angle;
        logic [RATE_W-1:0]  tilt_rate;
        logic [PULSE_W-1:0] left_pulses;
        logic [PULSE_W-1:0] right_pulses;
        logic               speed_update;
        logic [CMD_W-1:0]   speed_command;
        logic [CMD_W-1:0]   turn_command;
    } t_tick;

    typedef struct packed {
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
        logic               tilted_over;
    } t_drive;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sbc_in_if  tick_bus ();
    sbc_out_if drive_bus ();

    self_balance_cascade_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (tick_bus),
        .o_out       (drive_bus)
    );

    // Predictor copy of the configuration
    logic [GAIN_W-1:0] gain_tp   = sbc_pkg::RST_TILT_GAIN_P;
    logic [GAIN_W-1:0] gain_td   = sbc_pkg::RST_TILT_GAIN_D;
    logic [GAIN_W-1:0] gain_sp   = sbc_pkg::RST_SPEED_GAIN_P;
    logic [GAIN_W-1:0] gain_si   = sbc_pkg::RST_SPEED_GAIN_I;
    logic [PLIM_W-1:0] pos_limit = sbc_pkg::RST_POSITION_LIMIT;
    logic [DLIM_W-1:0] drive_lim = sbc_pkg::RST_DRIVE_LIMIT;
    logic [TLIM_W-1:0] tilt_lim  = sbc_pkg::RST_TILT_LIMIT;

    // Predictor copy of the loop state
    logic [PULSE_W-1:0] left_sum   = '0;
    logic [PULSE_W-1:0] right_sum  = '0;
    longint             speed_filt = 0;
    longint             position   = 0;
    longint             speed_term = 0;

    t_drive expected_drives [$];
    int     mismatch_count = 0;
    int     drives_seen    = 0;
    int     cycle_count    = 0;
    bit     calm           = 1'b0;
    bit     held_off       = 1'b0;

    // angle, rate, left, right, update, command, turn, typed, left, right, over
    int dir_tbl [0:DIR_ROWS-1][0:10] = '{
        '{0,      0,      0,      0,      0, 0,     0,     1, 0,    0,    0},
        '{0,      0,      0,      0,      0, 0,     2047,  1, 900,  -900, 0},
        '{0,      0,      0,      0,      0, 0,     -2048, 1, -900, 900,  0},
        '{46080,  0,      0,      0,      0, 0,     0,     1, 0,    0,    1},
        '{-46080, 0,      0,      0,      0, 0,     0,     1, 0,    0,    1},
        '{14080,  0,      0,      0,      0, 0,     0,     1, 0,    0,    1},
        '{-14080, 32767,  0,      0,      1, 2047,  0,     1, 0,    0,    1},
        '{14079,  0,      0,      0,      0, 0,     0,     0, 0,    0,    0},
        '{-14079, 0,      0,      0,      0, 0,     0,     0, 0,    0,    0},
        '{0,      32767,  0,      0,      0, 0,     0,     0, 0,    0,    0},
        '{0,      -32768, 0,      0,      0, 0,     0,     0, 0,    0,    0},
        '{0,      0,      32767,  -32768, 0, 0,     0,     0, 0,    0,    0},
        '{0,      0,      32767,  -32768, 0, 0,     0,     0, 0,    0,    0},
        '{0,      0,      -32768, 32767,  1, 2047,  0,     0, 0,    0,    0},
        '{0,      0,      100,    -100,   1, -2048, 0,     0, 0,    0,    0},
        '{256,    16,     5,      -5,     1, 0,     100,   0, 0,    0,    0},
        '{-256,   -16,    -5,     5,      1, 0,     -100,  0, 0,    0,    0},
        '{46080,  -32768, -32768, 32767,  1, -2048, -2048, 1, 0,    0,    1},
        '{0,      0,      0,      0,      1, 0,     0,     0, 0,    0,    0},
        '{1000,   -500,   40,     -40,    0, 0,     0,     0, 0,    0,    0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Round to nearest, halves away from zero
    function automatic longint round_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Advance the loop state by one tick and form the drives it yields
    function automatic t_drive predict_drive(t_tick t);
        longint one, angle, rate, cmd, turn, wheel_sum, tlim, base, tv, den, lim;
        t_drive d;
        one   = longint'(1) << FRAC_BITS;
        angle = longint'($signed(t.tilt_angle));
        rate  = longint'($signed(t.tilt_rate));
        cmd   = longint'($signed(t.speed_command));
        turn  = longint'($signed(t.turn_command));
        d     = '0;

        // Accumulate pulses, right side negated, both wrapping
        left_sum  = left_sum + t.left_pulses;
        right_sum = right_sum - t.right_pulses;

        // Run the speed loop on request
        if (t.speed_update) begin
            wheel_sum  = longint'($signed(left_sum)) + longint'($signed(right_sum));
            speed_filt = round_div(8 * speed_filt + wheel_sum * one, 10);
            position   = position + cmd * one
                       + round_div(longint'(gain_si) * speed_filt, one);
            position   = clamp_sym(position, longint'(pos_limit) * one);
            speed_term = round_div(longint'(gain_sp) * speed_filt, one) + position;
            if (speed_term > 64'sd2147483647)
                speed_term = 64'sd2147483647;
            if (speed_term < -64'sd2147483648)
                speed_term = -64'sd2147483648;
            left_sum  = '0;
            right_sum = '0;
        end

        // Stop the motors past the tilt limit, else form both drives
        tlim = longint'(tilt_lim) * 256;
        if (!(angle < tlim && angle > -tlim)) begin
            d.tilted_over = 1'b1;
            position      = 0;
        end else begin
            base = longint'(gain_tp) * angle - 16 * longint'(gain_td) * rate
                 - 256 * speed_term;
            tv   = 256 * turn * one;
            den  = one * 256;
            lim  = longint'(drive_lim);
            d.left_drive  = DRIVE_W'(clamp_sym(round_div(base + tv, den), lim));
            d.right_drive = DRIVE_W'(clamp_sym(round_div(base - tv, den), lim));
        end
        return d;
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            sbc_pkg::REG_TILT_GAIN_P:    gain_tp   = val;
            sbc_pkg::REG_TILT_GAIN_D:    gain_td   = val;
            sbc_pkg::REG_SPEED_GAIN_P:   gain_sp   = val;
            sbc_pkg::REG_SPEED_GAIN_I:   gain_si   = val;
            sbc_pkg::REG_POSITION_LIMIT: pos_limit = val[PLIM_W-1:0];
            sbc_pkg::REG_DRIVE_LIMIT:    drive_lim = val[DLIM_W-1:0];
            sbc_pkg::REG_TILT_LIMIT:     tilt_lim  = val[TLIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drain the block, then load a full register setting
    task automatic load_settings(int tp, int td, int sp, int si, int pl, int dl, int tl);
        tick_bus.valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        write_cfg(sbc_pkg::REG_TILT_GAIN_P, CFG_DATA_W'(tp));
        write_cfg(sbc_pkg::REG_TILT_GAIN_D, CFG_DATA_W'(td));
        write_cfg(sbc_pkg::REG_SPEED_GAIN_P, CFG_DATA_W'(sp));
        write_cfg(sbc_pkg::REG_SPEED_GAIN_I, CFG_DATA_W'(si));
        write_cfg(sbc_pkg::REG_POSITION_LIMIT, CFG_DATA_W'(pl));
        write_cfg(sbc_pkg::REG_DRIVE_LIMIT, CFG_DATA_W'(dl));
        write_cfg(sbc_pkg::REG_TILT_LIMIT, CFG_DATA_W'(tl));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one tick, hold until accepted, then queue its expected drives
    task automatic send_tick(t_tick t, bit typed, t_drive typed_drive);
        t_drive predicted;
        tick_bus.valid         <= 1'b1;
        tick_bus.tilt_angle    <= t.tilt_angle;
        tick_bus.tilt_rate     <= t.tilt_rate;
        tick_bus.left_pulses   <= t.left_pulses;
        tick_bus.right_pulses  <= t.right_pulses;
        tick_bus.speed_update  <= t.speed_update;
        tick_bus.speed_command <= t.speed_command;
        tick_bus.turn_command  <= t.turn_command;
        @(posedge i_clk);
        while (!tick_bus.ready)
            @(posedge i_clk);
        predicted = predict_drive(t);
        expected_drives.push_back(typed ? typed_drive : predicted);
        // Idle the sender now and then
        if (!calm && $urandom_range(0, 3) == 0) begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Random ticks: mostly upright with plausible pulses, some full-range noise
    task automatic run_random(int count, int pulse_bias);
        t_tick t;
        t_drive none;
        int m, sel, sgn;
        none = '0;
        for (int n = 0; n < count; n++) begin
            m   = (tilt_lim == 0) ? 46080 : int'(tilt_lim) * 256 - 1;
            m   = (m > 46080) ? 46080 : m;
            sel = $urandom_range(0, 19);
            if (sel < 8)
                t.tilt_angle = ANGLE_W'(int'($urandom_range(0, 1024)) - 512);
            else if (sel < 17)
                t.tilt_angle = ANGLE_W'(int'($urandom_range(0, 2 * m)) - m);
            else
                t.tilt_angle = ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
            t.tilt_rate = ($urandom_range(0, 1) == 0)
                        ? RATE_W'(int'($urandom_range(0, 512)) - 256)
                        : RATE_W'($urandom_range(0, 65535));
            sel = $urandom_range(0, 9);
            sgn = (pulse_bias != 0) ? pulse_bias : (($urandom_range(0, 1) == 0) ? 1 : -1);
            if (sel < 6) begin
                t.left_pulses  = PULSE_W'(int'($urandom_range(0, 128)) - 64);
                t.right_pulses = PULSE_W'(int'($urandom_range(0, 128)) - 64);
            end else if (sel < 8) begin
                t.left_pulses  = PULSE_W'(sgn * int'($urandom_range(16384, 32767)));
                t.right_pulses = PULSE_W'(-sgn * int'($urandom_range(16384, 32767)));
            end else begin
                t.left_pulses  = PULSE_W'($urandom_range(0, 65535));
                t.right_pulses = PULSE_W'($urandom_range(0, 65535));
            end
            t.speed_update  = ($urandom_range(0, 2) == 0);
            t.speed_command = ($urandom_range(0, 1) == 0)
                            ? CMD_W'(int'($urandom_range(0, 64)) - 32)
                            : CMD_W'($urandom_range(0, 4095));
            t.turn_command  = ($urandom_range(0, 1) == 0)
                            ? CMD_W'(int'($urandom_range(0, 64)) - 32)
                            : CMD_W'($urandom_range(0, 4095));
            send_tick(t, 1'b0, none);
        end
    endtask

    // Stimulus
    initial begin
        t_tick  t;
        t_drive typed_drive;
        tick_bus.valid         <= 1'b0;
        tick_bus.tilt_angle    <= '0;
        tick_bus.tilt_rate     <= '0;
        tick_bus.left_pulses   <= '0;
        tick_bus.right_pulses  <= '0;
        tick_bus.speed_update  <= 1'b0;
        tick_bus.speed_command <= '0;
        tick_bus.turn_command  <= '0;
        i_cfg_wr_en            <= 1'b0;
        i_cfg_index            <= '0;
        i_cfg_data             <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table on the reset setting
        for (int i = 0; i < DIR_ROWS; i++) begin
            t.tilt_angle              = ANGLE_W'(dir_tbl[i][0]);
            t.tilt_rate               = RATE_W'(dir_tbl[i][1]);
            t.left_pulses             = PULSE_W'(dir_tbl[i][2]);
            t.right_pulses            = PULSE_W'(dir_tbl[i][3]);
            t.speed_update            = (dir_tbl[i][4] != 0);
            t.speed_command           = CMD_W'(dir_tbl[i][5]);
            t.turn_command            = CMD_W'(dir_tbl[i][6]);
            typed_drive.left_drive    = DRIVE_W'(dir_tbl[i][8]);
            typed_drive.right_drive   = DRIVE_W'(dir_tbl[i][9]);
            typed_drive.tilted_over   = (dir_tbl[i][10] != 0);
            send_tick(t, dir_tbl[i][7] != 0, typed_drive);
        end

        // Reset setting, with the long receiver hold-off in here
        run_random(200, 0);

        // Every register but the tilt limit at its top value, pulses pushing the speed term to saturate
        load_settings(65535, 65535, 65535, 65535, 32767, 4095, 180);
        run_random(220, 1);

        // Every register at zero: the tilt stop always fires
        load_settings(0, 0, 0, 0, 0, 0, 0);
        run_random(120, -1);

        // Random setting
        load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 32767), $urandom_range(0, 4095),
                      $urandom_range(0, 180));
        run_random(220, int'($urandom_range(0, 2)) - 1);

        // Random setting, then run flat out with no idling
        load_settings($urandom_range(0, 65535), $urandom_range(0, 8191),
                      $urandom_range(0, 16383), $urandom_range(0, 1023),
                      $urandom_range(1, 32767), $urandom_range(1, 4095),
                      $urandom_range(1, 180));
        calm = 1'b1;
        run_random(220, 0);

        // Drain and finish
        tick_bus.valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none in the calm part
    initial begin
        drive_bus.ready <= 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held_off && drives_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                drive_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                drive_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                drive_bus.ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Check each drive transaction against the oldest expectation
    always @(posedge i_clk) begin : check_drives
        t_drive want;
        if (i_rst_n && drive_bus.valid && drive_bus.ready) begin
            drives_seen++;
            if (expected_drives.size() == 0) begin
                $error("drive transaction with no tick pending");
                mismatch_count++;
            end else begin
                want = expected_drives.pop_front();
                if (want.left_drive !== drive_bus.left_drive) begin
                    $error("left_drive: expected %0d, got %0d",
                           $signed(want.left_drive), $signed(drive_bus.left_drive));
                    mismatch_count++;
                end
                if (want.right_drive !== drive_bus.right_drive) begin
                    $error("right_drive: expected %0d, got %0d",
                           $signed(want.right_drive), $signed(drive_bus.right_drive));
                    mismatch_count++;
                end
                if (want.tilted_over !== drive_bus.tilted_over) begin
                    $error("tilted_over: expected %0d, got %0d",
                           want.tilted_over, drive_bus.tilted_over);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
